FILE: src/asmc_pkg.sv
`timescale 1ns / 1ps

package asmc_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STOP   = 2'd1,
        OP_SNOOZE = 2'd2
    } op_e;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ALARM_ENABLED  = 3'd0,
        CFG_ALARM_HOUR     = 3'd1,
        CFG_ALARM_MINUTE   = 3'd2,
        CFG_SNOOZE_MINUTES = 3'd3,
        CFG_NOTE_PERIOD_MS = 3'd4
    } cfg_idx_e;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic        ALARM_ENABLED_RST  = 1'b0;
    localparam logic [4:0]  ALARM_HOUR_RST     = 5'd7;
    localparam logic [5:0]  ALARM_MINUTE_RST   = 6'd0;
    localparam logic [5:0]  SNOOZE_MINUTES_RST = 6'd5;
    localparam logic [7:0]  NOTE_PERIOD_RST    = 8'd120;

    localparam logic [15:0] MS_PER_MINUTE      = 16'd60000;
    localparam logic [7:0]  NOTE_TIMER_MAX     = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic       time_valid;
    } in_item_t;

    typedef struct packed {
        logic        tone_write;
        logic [10:0] tone_hz;
        logic        ringing;
        logic        snoozing;
        logic        ring_started;
    } out_item_t;

    typedef struct packed {
        logic       alarm_enabled;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [5:0] snooze_minutes;
        logic [7:0] note_period_ms;
    } cfg_t;

    // Melody table; every odd step is a rest and entries past the tune are silence.
    function automatic logic [10:0] melody_note(input logic [5:0] idx);
        logic [10:0] hz;
        hz = 11'd0;
        case (idx)
            6'd0, 6'd8:   hz = 11'd196;
            6'd2, 6'd10:  hz = 11'd164;
            6'd4, 6'd12:  hz = 11'd146;
            6'd6, 6'd14:  hz = 11'd130;
            6'd16:        hz = 11'd262;
            6'd18:        hz = 11'd330;
            6'd20:        hz = 11'd392;
            6'd22, 6'd38: hz = 11'd523;
            6'd24, 6'd28, 6'd34: hz = 11'd784;
            6'd26, 6'd36: hz = 11'd659;
            6'd30:        hz = 11'd1047;
            6'd32:        hz = 11'd880;
            default:      hz = 11'd0;
        endcase
        return hz;
    endfunction

endpackage

FILE: src/asmc_engine.sv
`timescale 1ns / 1ps

module asmc_engine #(
    parameter int MELODY_LEN = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  asmc_pkg::in_item_t item,
    input  asmc_pkg::cfg_t    cfg,
    output asmc_pkg::out_item_t result
);
    import asmc_pkg::*;

    localparam logic [6:0] MEL_LEN = 7'(MELODY_LEN);

    logic        ring_reg, ring_next;
    logic        snooze_reg, snooze_next;
    logic        latch_reg, latch_next;
    logic [5:0]  note_idx_reg, note_idx_next;
    logic [7:0]  note_ms_reg, note_ms_next;
    logic [21:0] snooze_left_reg, snooze_left_next;

    logic [7:0]  note_ms_inc;
    logic [6:0]  note_idx_inc;
    logic [21:0] snooze_left_dec;
    logic [21:0] snooze_load;
    logic        tone_wr;
    logic [10:0] tone_hz;
    logic        started;

    assign snooze_load = 22'(cfg.snooze_minutes) * 22'(MS_PER_MINUTE);
    assign note_ms_inc = (note_ms_reg != NOTE_TIMER_MAX) ? note_ms_reg + 8'd1 : note_ms_reg;
    assign note_idx_inc = {1'b0, note_idx_reg} + 7'd1;
    assign snooze_left_dec = (snooze_left_reg != 22'd0) ? snooze_left_reg - 22'd1
                                                       : snooze_left_reg;

    always_comb
    begin
        ring_next        = ring_reg;
        snooze_next      = snooze_reg;
        latch_next       = latch_reg;
        note_idx_next    = note_idx_reg;
        note_ms_next     = note_ms_reg;
        snooze_left_next = snooze_left_reg;
        tone_wr          = 1'b0;
        tone_hz          = 11'd0;
        started          = 1'b0;
        case (item.operation)
            OP_TICK:
            begin
                if (ring_reg)
                begin
                    note_ms_next = note_ms_inc;
                    if (note_ms_inc >= cfg.note_period_ms)
                    begin
                        note_ms_next = 8'd0;
                        tone_wr      = 1'b1;
                        tone_hz      = ({1'b0, note_idx_reg} < MEL_LEN)
                                       ? melody_note(note_idx_reg) : 11'd0;
                        note_idx_next = (note_idx_inc >= MEL_LEN) ? 6'd0 : note_idx_inc[5:0];
                    end
                end
                else if (snooze_reg)
                begin
                    snooze_left_next = snooze_left_dec;
                    if (snooze_left_dec == 22'd0)
                    begin
                        ring_next     = 1'b1;
                        snooze_next   = 1'b0;
                        note_idx_next = 6'd0;
                        note_ms_next  = NOTE_TIMER_MAX;
                        started       = 1'b1;
                    end
                end
                else if (!cfg.alarm_enabled)
                begin
                    latch_next = 1'b0;
                end
                else if (item.time_valid)
                begin
                    if (item.hour_now == cfg.alarm_hour &&
                        item.minute_now == cfg.alarm_minute && !latch_reg)
                    begin
                        latch_next    = 1'b1;
                        ring_next     = 1'b1;
                        snooze_next   = 1'b0;
                        note_idx_next = 6'd0;
                        note_ms_next  = NOTE_TIMER_MAX;
                        started       = 1'b1;
                    end
                    // The latch is released once the clock has left the alarm minute.
                    if (item.minute_now != cfg.alarm_minute)
                        latch_next = 1'b0;
                end
            end
            OP_STOP:
            begin
                ring_next   = 1'b0;
                snooze_next = 1'b0;
                tone_wr     = 1'b1;
            end
            OP_SNOOZE:
            begin
                ring_next        = 1'b0;
                snooze_next      = 1'b1;
                snooze_left_next = snooze_load;
                tone_wr          = 1'b1;
            end
            default:
            begin
                tone_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg        <= 1'b0;
            snooze_reg      <= 1'b0;
            latch_reg       <= 1'b0;
            note_idx_reg    <= 6'd0;
            note_ms_reg     <= 8'd0;
            snooze_left_reg <= 22'd0;
        end
        else if (step_en)
        begin
            ring_reg        <= ring_next;
            snooze_reg      <= snooze_next;
            latch_reg       <= latch_next;
            note_idx_reg    <= note_idx_next;
            note_ms_reg     <= note_ms_next;
            snooze_left_reg <= snooze_left_next;
        end
    end

    assign result.tone_write   = tone_wr;
    assign result.tone_hz      = tone_hz;
    assign result.ringing      = ring_next;
    assign result.snoozing     = snooze_next;
    assign result.ring_started = started;

endmodule

FILE: src/alarm_snooze_melody_controller_core.sv
`timescale 1ns / 1ps

// Alarm controller with snooze and a looping melody.
// Input channel (item_valid / item_stall / item): one item per millisecond tick
// carrying the time of day, or a stop or snooze button event.
// Output channel (result_valid / result_stall / result): exactly one result per
// item, giving any buzzer tone write and the ringing and snoozing status.
// Configuration: cfg_write writes cfg_data into the register at cfg_index on a
// clock edge; writes take effect at once. Writes are to be made only while
// the block is idle; the block itself does not enforce this. An item taken
// sits in the input register, is worked on by the step logic and its result is
// loaded into the output register. One item is taken every cycle while
// item_stall is low; the step logic updates its state once per item.
// When the receiver stalls, the result is held, one more item can wait in the
// input register, and item_stall is raised only once both are full.
// Reset clears all status and restores the register defaults (alarm disabled,
// 07:00, five minute snooze, 120 ms note period).
module alarm_snooze_melody_controller_core #(
    parameter int MELODY_LEN = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  asmc_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output asmc_pkg::out_item_t               result,
    input  logic                              cfg_write,
    input  logic [asmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [asmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import asmc_pkg::*;

    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t result_reg;
    logic      result_valid_reg;
    cfg_t      cfg_reg;
    out_item_t step_result;
    logic      advance;
    logic      take;

    // The input register moves on whenever the output register is free or is
    // being emptied by a transfer in this cycle.
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = item_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    asmc_engine #(
        .MELODY_LEN(MELODY_LEN)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(item_valid_reg && advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
        if (advance && item_valid_reg)
            result_reg <= step_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_enabled  <= ALARM_ENABLED_RST;
            cfg_reg.alarm_hour     <= ALARM_HOUR_RST;
            cfg_reg.alarm_minute   <= ALARM_MINUTE_RST;
            cfg_reg.snooze_minutes <= SNOOZE_MINUTES_RST;
            cfg_reg.note_period_ms <= NOTE_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ALARM_ENABLED:  cfg_reg.alarm_enabled  <= cfg_data[0];
                CFG_ALARM_HOUR:     cfg_reg.alarm_hour     <= cfg_data[4:0];
                CFG_ALARM_MINUTE:   cfg_reg.alarm_minute   <= cfg_data[5:0];
                CFG_SNOOZE_MINUTES: cfg_reg.snooze_minutes <= cfg_data[5:0];
                CFG_NOTE_PERIOD_MS: cfg_reg.note_period_ms <= cfg_data;
                default:            cfg_reg.alarm_enabled  <= cfg_reg.alarm_enabled;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The alarm is never ringing and snoozing at once.
    a_ring_snooze_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.ringing && result_reg.snoozing))
        else $error("ringing and snoozing both set");

    // A ring that starts is reported as ringing in the same result.
    a_start_rings: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.ring_started) |-> result_reg.ringing)
        else $error("ring started without ringing");

    // A result without a buzzer write carries no frequency.
    a_no_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.tone_write) |-> (result_reg.tone_hz == 11'd0))
        else $error("tone frequency without a write");

    // Input is held back only while both stages are full and the output is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid_reg && result_stall && item_valid_reg))
        else $error("input stalled without a full pipeline");

endmodule

FILE: dv/alarm_tone_checker.sv
`timescale 1ns / 1ps

module alarm_tone_checker #(
    parameter int MELODY_LEN = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  asmc_pkg::in_item_t                item,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  asmc_pkg::out_item_t               result,
    input  logic                              cfg_write,
    input  logic [asmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [asmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int unsigned                       outstanding,
    output int unsigned                       mismatch_count
);
    import asmc_pkg::*;

    localparam int TUNE_STEPS = 40;

    // Odd steps are rests.
    localparam logic [10:0] TUNE_HZ [0:TUNE_STEPS-1] = '{
        11'd196, 11'd0, 11'd164, 11'd0, 11'd146, 11'd0, 11'd130, 11'd0,
        11'd196, 11'd0, 11'd164, 11'd0, 11'd146, 11'd0, 11'd130, 11'd0,
        11'd262, 11'd0, 11'd330, 11'd0, 11'd392, 11'd0, 11'd523, 11'd0,
        11'd784, 11'd0, 11'd659, 11'd0, 11'd784, 11'd0, 11'd1047, 11'd0,
        11'd880, 11'd0, 11'd784, 11'd0, 11'd659, 11'd0, 11'd523, 11'd0
    };

    cfg_t        alarm_cfg;
    logic        ringing_now;
    logic        snoozing_now;
    logic        matched_this_minute;
    logic [5:0]  tune_pos;
    logic [7:0]  note_age;
    logic [21:0] snooze_ticks_left;

    out_item_t   pending_outputs [$];
    out_item_t   wanted;
    int unsigned results_seen;

    function automatic void start_ringing();
        ringing_now  = 1'b1;
        snoozing_now = 1'b0;
        tune_pos     = 6'd0;
        note_age     = 8'hFF;
    endfunction

    function automatic out_item_t predict_alarm_output(in_item_t it);
        out_item_t   o;
        logic [5:0]  next_pos;
        logic [31:0] span;
        o = '0;
        case (it.operation)
            OP_TICK: begin
                if (ringing_now) begin
                    if (note_age != 8'hFF)
                        note_age = note_age + 8'd1;
                    if (note_age >= alarm_cfg.note_period_ms) begin
                        note_age = 8'd0;
                        o.tone_write = 1'b1;
                        if (tune_pos < MELODY_LEN && tune_pos < TUNE_STEPS)
                            o.tone_hz = TUNE_HZ[tune_pos];
                        next_pos = tune_pos + 6'd1;
                        if (next_pos >= MELODY_LEN)
                            next_pos = 6'd0;
                        tune_pos = next_pos;
                    end
                end else if (snoozing_now) begin
                    if (snooze_ticks_left != 22'd0)
                        snooze_ticks_left = snooze_ticks_left - 22'd1;
                    if (snooze_ticks_left == 22'd0) begin
                        start_ringing();
                        o.ring_started = 1'b1;
                    end
                end else if (!alarm_cfg.alarm_enabled) begin
                    matched_this_minute = 1'b0;
                end else if (it.time_valid) begin
                    if (it.hour_now == alarm_cfg.alarm_hour &&
                        it.minute_now == alarm_cfg.alarm_minute && !matched_this_minute) begin
                        matched_this_minute = 1'b1;
                        start_ringing();
                        o.ring_started = 1'b1;
                    end
                    if (it.minute_now != alarm_cfg.alarm_minute)
                        matched_this_minute = 1'b0;
                end
            end
            OP_STOP: begin
                ringing_now  = 1'b0;
                snoozing_now = 1'b0;
                o.tone_write = 1'b1;
            end
            OP_SNOOZE: begin
                ringing_now  = 1'b0;
                snoozing_now = 1'b1;
                span = alarm_cfg.snooze_minutes * 32'd60000;
                snooze_ticks_left = span[21:0];
                o.tone_write = 1'b1;
            end
            default: ;
        endcase
        o.ringing  = ringing_now;
        o.snoozing = snoozing_now;
        return o;
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (cfg_idx_e'(idx))
            CFG_ALARM_ENABLED:  alarm_cfg.alarm_enabled  = data[0];
            CFG_ALARM_HOUR:     alarm_cfg.alarm_hour     = data[4:0];
            CFG_ALARM_MINUTE:   alarm_cfg.alarm_minute   = data[5:0];
            CFG_SNOOZE_MINUTES: alarm_cfg.snooze_minutes = data[5:0];
            CFG_NOTE_PERIOD_MS: alarm_cfg.note_period_ms = data[7:0];
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic compare_field(string name, logic [10:0] got, logic [10:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            alarm_cfg.alarm_enabled  = ALARM_ENABLED_RST;
            alarm_cfg.alarm_hour     = ALARM_HOUR_RST;
            alarm_cfg.alarm_minute   = ALARM_MINUTE_RST;
            alarm_cfg.snooze_minutes = SNOOZE_MINUTES_RST;
            alarm_cfg.note_period_ms = NOTE_PERIOD_RST;
            ringing_now         = 1'b0;
            snoozing_now        = 1'b0;
            matched_this_minute = 1'b0;
            tune_pos            = 6'd0;
            note_age            = 8'd0;
            snooze_ticks_left   = 22'd0;
            results_seen        = 0;
            mismatch_count      = 0;
            pending_outputs.delete();
            outstanding <= 0;
        end else begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);
            // The result side is settled first so that an item taken at this edge
            // cannot be paired with a result that belongs to an older transfer.
            if (result_valid && !result_stall) begin
                if (pending_outputs.size() == 0) begin
                    flag_mismatch("result arrived with nothing outstanding");
                end else begin
                    wanted = pending_outputs.pop_front();
                    compare_field("tone_write", 11'(result.tone_write),
                                  11'(wanted.tone_write));
                    compare_field("tone_hz", result.tone_hz, wanted.tone_hz);
                    compare_field("ringing", 11'(result.ringing), 11'(wanted.ringing));
                    compare_field("snoozing", 11'(result.snoozing), 11'(wanted.snoozing));
                    compare_field("ring_started", 11'(result.ring_started),
                                  11'(wanted.ring_started));
                end
                results_seen = results_seen + 1;
            end
            if (item_valid && !item_stall)
                pending_outputs.push_back(predict_alarm_output(item));
            outstanding <= pending_outputs.size();
        end
    end

endmodule

FILE: dv/alarm_snooze_melody_controller_core_test.sv
`timescale 1ns / 1ps

module alarm_snooze_melody_controller_core_test;

    import asmc_pkg::*;

    localparam int         TUNE_LEN     = 40;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PHASES       = 5;
    localparam int         PHASE_ITEMS  = 270;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    in_item_t                item;
    logic                    result_valid;
    logic                    result_stall;
    out_item_t               result;
    logic                    cfg_write;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned random_done;

    alarm_snooze_melody_controller_core #(
        .MELODY_LEN (TUNE_LEN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    alarm_tone_checker #(
        .MELODY_LEN (TUNE_LEN)
    ) tone_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(0, 99) < receiver_idle_pct);
    end

    function automatic cfg_t alarm_setting(logic en, logic [4:0] hr, logic [5:0] mn,
                                           logic [5:0] snooze, logic [7:0] period);
        cfg_t c;
        c.alarm_enabled  = en;
        c.alarm_hour     = hr;
        c.alarm_minute   = mn;
        c.snooze_minutes = snooze;
        c.note_period_ms = period;
        return c;
    endfunction

    function automatic in_item_t make_item(logic [1:0] op, logic [4:0] hr, logic [5:0] mn,
                                           logic valid);
        in_item_t it;
        it.operation  = op;
        it.hour_now   = hr;
        it.minute_now = mn;
        it.time_valid = valid;
        return it;
    endfunction

    // Mostly ticks near the alarm time, so that the match, the latch and the
    // melody are all reached; buttons and the unused code are the noise.
    function automatic in_item_t random_item(cfg_t c, int unsigned button_pct);
        in_item_t    it;
        int unsigned pick;
        it.hour_now   = 5'($urandom);
        it.minute_now = 6'($urandom);
        it.time_valid = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < button_pct)
            it.operation = OP_STOP;
        else if (pick < 2 * button_pct)
            it.operation = OP_SNOOZE;
        else if (pick < 2 * button_pct + 2)
            it.operation = OP_UNUSED;
        else
            it.operation = OP_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.hour_now   = c.alarm_hour;
            it.minute_now = c.alarm_minute;
        end else if (pick < 75) begin
            it.hour_now   = c.alarm_hour;
            it.minute_now = c.alarm_minute + 6'd1;
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Unused upper bits of each register write carry random noise.
    task automatic program_alarm(cfg_t c);
        logic [7:0] noise;
        drain_results();
        noise = 8'($urandom);
        put_reg(CFG_ALARM_ENABLED, {noise[6:0], c.alarm_enabled});
        put_reg(CFG_ALARM_HOUR, {noise[7:5], c.alarm_hour});
        put_reg(CFG_ALARM_MINUTE, {noise[2:1], c.alarm_minute});
        put_reg(CFG_SNOOZE_MINUTES, {noise[4:3], c.snooze_minutes});
        put_reg(CFG_NOTE_PERIOD_MS, c.note_period_ms);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        cfg_t        setting;
        int unsigned button_pct;

        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        result_stall      = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        sender_idle_pct   = 10;
        receiver_idle_pct = 61;
        random_done       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: match, notes, snooze of zero length, latch, invalid time.
        setting = alarm_setting(1'b1, 5'd7, 6'd0, 6'd0, 8'd1);
        program_alarm(setting);
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_TICK, 5'd0, 6'd0, 1'b0));
        send_item(make_item(OP_TICK, 5'd31, 6'd63, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b0));
        send_item(make_item(OP_SNOOZE, 5'd31, 6'd63, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_STOP, 5'd0, 6'd0, 1'b0));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd1, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b0));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_UNUSED, 5'd31, 6'd63, 1'b1));
        send_item(make_item(OP_STOP, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_STOP, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_SNOOZE, 5'd0, 6'd0, 1'b0));
        send_item(make_item(OP_TICK, 5'd0, 6'd0, 1'b0));
        send_item(make_item(OP_STOP, 5'd0, 6'd0, 1'b0));
        setting = alarm_setting(1'b0, 5'd7, 6'd0, 6'd0, 8'd0);
        program_alarm(setting);
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_SNOOZE, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_TICK, 5'd7, 6'd0, 1'b1));
        send_item(make_item(OP_UNUSED, 5'd0, 6'd0, 1'b0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin
                    setting    = alarm_setting(1'b1, 5'd7, 6'd0, 6'd0, 8'd1);
                    button_pct = 1;
                end
                1: begin
                    setting    = alarm_setting(1'b1, 5'd23, 6'd59, 6'd0, 8'd3);
                    button_pct = 5;
                end
                2: begin
                    setting    = alarm_setting(1'b0, 5'd0, 6'd0, 6'd0, 8'd0);
                    button_pct = 5;
                end
                3: begin
                    setting    = alarm_setting(1'b1, 5'd31, 6'd63, 6'd60, 8'd255);
                    button_pct = 2;
                end
                default: begin
                    setting = alarm_setting(1'b1, 5'($urandom_range(0, 23)),
                                            6'($urandom_range(0, 59)),
                                            6'd63, 8'($urandom_range(1, 10)));
                    button_pct = 4;
                end
            endcase
            program_alarm(setting);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (random_done < 450) begin
                    sender_idle_pct   = 10;
                    receiver_idle_pct = 61;
                end else if (random_done < 900) begin
                    sender_idle_pct   = 61;
                    receiver_idle_pct = 10;
                end else begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
                // Now and then hold off until the result side has caught up.
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                send_item(random_item(setting, button_pct));
                random_done++;
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
